// ----- sv/utrd_pkg.sv -----
// ----------------------------------------------------------------------------
// utrd_pkg
// Shared constants and controller/datapath interface types for the unsigned
// to radix digit converter.
// ----------------------------------------------------------------------------
package utrd_pkg;

   localparam int IN_W        = 64;
   localparam int VALUE_WIDTH = 64;
   localparam int MAX_DIGITS  = 64;
   localparam int RADIX_W     = 4;
   localparam int CHAR_W      = 6;
   localparam int STEP_BITS   = 8;

   localparam int CHUNKS = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
   localparam int PAD_W  = CHUNKS * STEP_BITS;
   localparam int STEP_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
   localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
   localparam int ADDR_W = $clog2(MAX_DIGITS);

   localparam logic [RADIX_W-1:0] RADIX_MIN   = 4'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 4'd10;
   localparam logic [RADIX_W-1:0] RADIX_RESET = 4'd10;
   localparam logic [CHAR_W-1:0]  DIGIT_ZERO  = 6'd48;

   typedef struct packed {
      logic load;
      logic div_step;
      logic prime;
      logic emit;
      logic emit_next;
   } utrd_cmd_type;

   typedef struct packed {
      logic step_last;
      logic quot_zero;
      logic count_full;
      logic emit_last;
   } utrd_sts_type;

endpackage

// ----- sv/utrd_ram.sv -----
// ----------------------------------------------------------------------------
// utrd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module utrd_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/utrd_dpath.sv -----
// ----------------------------------------------------------------------------
// utrd_dpath
// Radix register, shift-and-subtract divider (STEP_BITS quotient bits per
// cycle), digit store and read-back index.
// ----------------------------------------------------------------------------
module utrd_dpath import utrd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  utrd_cmd_type       cmd,
   output utrd_sts_type       sts,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [RADIX_W-1:0] csr_radix,
   input  logic [IN_W-1:0]    req_value,
   output logic [CHAR_W-1:0]  rsp_digit_char
);

   logic [RADIX_W-1:0]   radix_ff, radix_in;
   logic [PAD_W-1:0]     work_ff, work_in;
   logic [RADIX_W-1:0]   rem_ff, rem_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 nz_ff, nz_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [ADDR_W-1:0]    idx_ff, idx_in;

   logic [RADIX_W-1:0]   rem_v;
   logic [RADIX_W:0]     trial;
   logic [STEP_BITS-1:0] qbits;
   logic [ADDR_W-1:0]    cnt_m1;
   logic                 wr_en;
   logic                 rd_en;
   logic [ADDR_W-1:0]    rd_addr;
   logic [RADIX_W-1:0]   rd_data;

   assign csr_ready = 1'b1;

   always_comb begin
      radix_in = radix_ff;
      if (csr_valid) begin
         if (csr_radix < RADIX_MIN) begin
            radix_in = RADIX_MIN;
         end else if (csr_radix > RADIX_MAX) begin
            radix_in = RADIX_MAX;
         end else begin
            radix_in = csr_radix;
         end
      end
   end

   // restoring division of the top byte, remainder carried across cycles
   always_comb begin
      rem_v = rem_ff;
      trial = '0;
      qbits = '0;
      for (int i = STEP_BITS - 1; i >= 0; i--) begin
         trial = {rem_v, work_ff[PAD_W-STEP_BITS+i]};
         if (trial >= {1'b0, radix_ff}) begin
            trial    = trial - {1'b0, radix_ff};
            qbits[i] = 1'b1;
         end
         rem_v = trial[RADIX_W-1:0];
      end
   end

   assign sts.step_last  = (step_ff == STEP_W'(CHUNKS - 1));
   assign sts.quot_zero  = !nz_ff && (qbits == '0);
   assign sts.count_full = (cnt_ff == CNT_W'(MAX_DIGITS - 1));
   assign sts.emit_last  = (idx_ff == '0);

   assign cnt_m1 = ADDR_W'(cnt_ff - CNT_W'(1));

   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      nz_in   = nz_ff;
      cnt_in  = cnt_ff;
      idx_in  = idx_ff;
      if (cmd.load) begin
         work_in = PAD_W'(req_value[VALUE_WIDTH-1:0]);
         rem_in  = '0;
         step_in = '0;
         nz_in   = 1'b0;
         cnt_in  = '0;
      end else if (cmd.div_step) begin
         work_in = (work_ff << STEP_BITS) | PAD_W'(qbits);
         if (sts.step_last) begin
            rem_in  = '0;
            step_in = '0;
            nz_in   = 1'b0;
            cnt_in  = cnt_ff + CNT_W'(1);
         end else begin
            rem_in  = rem_v;
            step_in = step_ff + STEP_W'(1);
            nz_in   = nz_ff || (qbits != '0);
         end
      end
      if (cmd.prime) begin
         idx_in = cnt_m1;
      end else if (cmd.emit_next && !sts.emit_last) begin
         idx_in = idx_ff - ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
         step_ff  <= '0;
         nz_ff    <= 1'b0;
         cnt_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         radix_ff <= radix_in;
         step_ff  <= step_in;
         nz_ff    <= nz_in;
         cnt_ff   <= cnt_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
   end

   assign wr_en   = cmd.div_step && sts.step_last;
   assign rd_en   = cmd.prime || (cmd.emit_next && !sts.emit_last);
   assign rd_addr = cmd.prime ? cnt_m1 : idx_in;

   utrd_ram #(
      .WIDTH (RADIX_W),
      .DEPTH (MAX_DIGITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[ADDR_W-1:0]),
      .wr_data (rem_v),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_digit_char = DIGIT_ZERO + {{(CHAR_W - RADIX_W){1'b0}}, rd_data};

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_DIGITS))
      else $error("digit count beyond store depth");

   a_rem_below_radix: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> rem_ff < radix_ff)
      else $error("partial remainder not below radix");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> {1'b0, idx_ff} < cnt_ff)
      else $error("read-back index outside stored digits");

endmodule

// ----- sv/utrd_ctrl.sv -----
// ----------------------------------------------------------------------------
// utrd_ctrl
// Sequencer: accept, divide digit by digit, prime store read, emit digits.
// ----------------------------------------------------------------------------
module utrd_ctrl import utrd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output utrd_cmd_type cmd,
   input  utrd_sts_type sts
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DIVIDE = 4'b0010,
      ST_PRIME  = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);

   assign cmd.load      = (state_ff == ST_IDLE) && req_valid;
   assign cmd.div_step  = (state_ff == ST_DIVIDE);
   assign cmd.prime     = (state_ff == ST_PRIME);
   assign cmd.emit      = (state_ff == ST_EMIT);
   assign cmd.emit_next = (state_ff == ST_EMIT) && !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (sts.step_last && (sts.quot_zero || sts.count_full)) begin
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_stall && sts.emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && sts.emit_last) |=> !rsp_valid && !req_stall)
      else $error("block not idle after final digit taken");

   a_emit_after_prime: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == ST_PRIME)
      else $error("digit shown before store read primed");

endmodule

// ----- sv/unsigned_to_radix_digits.sv -----
// ----------------------------------------------------------------------------
// unsigned_to_radix_digits
// Converts an unsigned value to ASCII digits in radix 2..10, most
// significant first, last digit flagged.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_value[63:0]
//   rsp      out        rsp_valid / rsp_stall  rsp_digit_char[5:0], rsp_last_digit
//   csr      in         csr_valid / csr_ready  csr_radix[3:0]
//
// The divider retires 8 quotient bits per cycle while dividing; each digit
// takes one full pass over the value. Worst case (radix 2, top bit set) is
// 64 digits. One item at a time; req_stall is high from accept until the
// final digit is taken. Synchronous active-high reset sets radix to 10.
// ----------------------------------------------------------------------------
module unsigned_to_radix_digits import utrd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [IN_W-1:0]    req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [CHAR_W-1:0]  rsp_digit_char,
   output logic               rsp_last_digit,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [RADIX_W-1:0] csr_radix
);

   utrd_cmd_type cmd;
   utrd_sts_type sts;

   utrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   utrd_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_radix      (csr_radix),
      .req_value      (req_value),
      .rsp_digit_char (rsp_digit_char)
   );

   assign rsp_last_digit = sts.emit_last;

endmodule

// ----- sim/tb_unsigned_to_radix_digits.sv -----
// ----------------------------------------------------------------------------
// tb_unsigned_to_radix_digits
// Self-checking bench for the radix digit converter. Values go in on the req
// channel and are predicted by repeated division at the current radix. The
// expected ASCII digits are queued most significant first, and every digit
// taken from the rsp channel is compared against the head of that queue.
// A directed pass covers zero, radix edges, full-width values and out-of-range
// radix settings. Random values with mixed widths follow under several radix
// settings and idle patterns. One long output hold backs up the block.
// ----------------------------------------------------------------------------
module tb_unsigned_to_radix_digits import utrd_pkg::*; ();

   typedef struct {
      logic [CHAR_W-1:0] digit_char;
      logic              last_digit;
   } digit_type;

   class digit_ledger;
      logic [RADIX_W-1:0] radix_reg;
      digit_type          expected_digits[$];
      int                 errors;
      int                 digits_checked;

      function new();
         radix_reg      = RADIX_RESET;
         errors         = 0;
         digits_checked = 0;
      endfunction

      function void set_radix(logic [RADIX_W-1:0] r);
         radix_reg = r;
      endfunction

      function int pending();
         return expected_digits.size();
      endfunction

      // Divide down at the effective radix, then queue digits in reverse.
      function void note_value(logic [IN_W-1:0] v);
         logic [63:0]  base;
         logic [63:0]  rest;
         logic [3:0]   digs [MAX_DIGITS];
         int           n;
         digit_type    d;
         base = 64'(radix_reg);
         if (base < 2)
            base = 2;
         else if (base > 10)
            base = 10;
         rest = v;
         n = 0;
         do begin
            digs[n] = 4'(rest % base);
            rest    = rest / base;
            n++;
         end while (rest != 0 && n < MAX_DIGITS);
         for (int k = n - 1; k >= 0; k--) begin
            d.digit_char = DIGIT_ZERO + CHAR_W'(digs[k]);
            d.last_digit = (k == 0);
            expected_digits.push_back(d);
         end
      endfunction

      function void check_digit(logic [CHAR_W-1:0] c, logic l);
         digit_type d;
         if (expected_digits.size() == 0) begin
            $display("%0t: unexpected digit char=%0d last=%0b", $time, c, l);
            errors++;
            return;
         end
         d = expected_digits.pop_front();
         digits_checked++;
         if (c !== d.digit_char) begin
            $display("%0t: digit_char expected %0d actual %0d", $time, d.digit_char, c);
            errors++;
         end
         if (l !== d.last_digit) begin
            $display("%0t: last_digit expected %0b actual %0b", $time, d.last_digit, l);
            errors++;
         end
      endfunction
   endclass

   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 600;
   localparam int NUM_SEG     = 12;
   localparam int SEG_ITEMS   = 30;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [IN_W-1:0]    req_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [CHAR_W-1:0]  rsp_digit_char;
   logic               rsp_last_digit;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [RADIX_W-1:0] csr_radix = RADIX_RESET;

   digit_ledger ledger = new();
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          hold_asks = 0;
   int          values_sent = 0;
   int          radix_writes = 0;
   int          seg_radix [NUM_SEG] = '{3, 7, 9, 13, 2, 10, 5, 0, 4, 8, 6, 1};

   unsigned_to_radix_digits uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_radix      (csr_radix)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic send_value(input logic [IN_W-1:0] v);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_value <= {$urandom, $urandom};
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (req_stall);
      ledger.note_value(v);
      values_sent++;
   endtask

   task automatic drain_digits();
      req_valid <= 1'b0;
      while (ledger.pending() != 0)
         @(posedge clock);
   endtask

   task automatic write_radix(input int r);
      drain_digits();
      csr_valid <= 1'b1;
      csr_radix <= RADIX_W'(r);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      ledger.set_radix(RADIX_W'(r));
      radix_writes++;
   endtask

   function automatic logic [IN_W-1:0] pick_value();
      logic [IN_W-1:0] v;
      int              w;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: begin
            w = $urandom_range(1, 64);
            if (w < 64)
               v = v & ((64'd1 << w) - 64'd1);
         end
         5: v = v;
         6: v = 64'($urandom_range(0, 120));
         7: v = 64'd1 << $urandom_range(0, 63);
         8: v = (64'd1 << $urandom_range(1, 63)) - 64'd1;
         default: v = '1;
      endcase
      return v;
   endfunction

   // Output side: check taken digits, then choose the next stall.
   initial begin
      int hold_left;
      int holds_done;
      hold_left  = 0;
      holds_done = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            ledger.check_digit(rsp_digit_char, rsp_last_digit);
         if (hold_asks != holds_done) begin
            holds_done = hold_asks;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   initial begin
      #4_000_000;
      $display("timeout with %0d digits outstanding", ledger.pending());
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 38;
      recv_idle_pct = 55;

      // reset radix
      send_value(64'd0);
      send_value(64'd1);
      send_value(64'd9);
      send_value(64'd10);
      send_value(64'd99);
      send_value(64'd100);
      send_value(64'd10_000_000_000_000_000_000);
      send_value(64'd1844677407370955161);
      send_value(64'd1844677407370955162);
      send_value('1);

      write_radix(2);
      send_value(64'd0);
      send_value(64'd1);
      send_value('1);
      send_value(64'h8000_0000_0000_0000);

      // out-of-range radix settings clamp to 2 or 10
      write_radix(0);
      send_value(64'd5);
      send_value('1);
      write_radix(15);
      send_value(64'd12345);
      send_value('1);
      write_radix(1);
      send_value(64'd6);
      write_radix(11);
      send_value(64'd77);

      for (int seg = 0; seg < NUM_SEG; seg++) begin
         if (seg % 4 == 0) begin
            case (seg / 4)
               0: begin send_idle_pct = 38; recv_idle_pct = 55; end
               1: begin send_idle_pct = 55; recv_idle_pct = 38; end
               default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
         end
         write_radix(seg_radix[seg]);
         for (int i = 0; i < SEG_ITEMS; i++) begin
            if (seg == 8 && i == 3)
               hold_asks <= hold_asks + 1;
            send_value(pick_value());
         end
      end

      drain_digits();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Converted %0d values over %0d radix writes; %0d digits checked, %0d left over",
               values_sent, radix_writes, ledger.digits_checked, ledger.pending());
      if (ledger.errors == 0 && ledger.pending() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
